// ----- design/lkvc_pkg.sv -----
// shared types and constants for the lru key-value cache
// used by lkvc_ctrl, lkvc_datapath and the top level; no dependencies
package lkvc_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int CAP_W           = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_STORE  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request, restart scan
      logic scan_en;  // read one entry of the key/value memories
      logic act;      // apply the update and post the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last; // scan address is at the last entry
      logic act_ok;    // result register can take this request's answer
      logic lookup;    // request held is a lookup
   } status_type;

endpackage

// ----- design/lru_key_value_cache_unit.sv -----
// top level of the lru key-value cache: sequencer plus datapath
// depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata = key, value; tuser = kind
//   rsp_      out        rsp_tvalid/rsp_tready  tdata = data; tuser = found
//   csr_      in         csr_valid/csr_ready    csr_data = capacity
//
// each request is accepted, then the key/value memories are scanned one entry a cycle
// through their single read port, then a last compare state and an update state follow.
// reset clears valid bits, ranks and occupancy at once; no clearing pass.
// a lookup answer waits in the result register while the next request is taken;
// a later lookup holds in its update cycle until that register is emptied.
module lru_key_value_cache_unit #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key, [63:32] value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   lkvc_pkg::cmd_type    cmd;
   lkvc_pkg::status_type status;

   assign csr_ready = 1'b1;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lkvc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_tuser),
      .req_key    (req_tdata[31:0]),
      .req_value  (req_tdata[63:32]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_found  (rsp_tuser),
      .rsp_data   (rsp_tdata)
   );

`ifndef SYNTHESIS
   // an accepted transaction keeps the input closed while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // a finished lookup always shows up on the result channel
   a_lookup_answers: assert property (@(posedge clock) disable iff (reset)
      (cmd.act && status.lookup) |=> rsp_tvalid)
      else $error("lookup finished without a result");

   // the scan ends after its last entry
   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_en && status.scan_last) |=> !cmd.scan_en)
      else $error("scan ran past the last entry");
`endif

endmodule

// ----- design/lkvc_ctrl.sv -----
// sequencer for the lru key-value cache: accept, scan, last compare, update
// depends on lkvc_pkg
module lkvc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lkvc_pkg::status_type  status,
   output lkvc_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_ACT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            if (status.act_ok) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready  = (state_ff == ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.scan_en = (state_ff == ST_SCAN);
   assign cmd.act     = (state_ff == ST_ACT) && status.act_ok;

endmodule

// ----- design/lkvc_datapath.sv -----
// datapath of the lru key-value cache: key/value memories, valid bits,
// recency ranks, occupancy, capacity register and result register; uses lkvc_pkg
module lkvc_datapath #(
   parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkvc_pkg::cmd_type             cmd,
   output lkvc_pkg::status_type          status,
   input  logic                          req_kind,
   input  logic [lkvc_pkg::KEY_W-1:0]    req_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]  req_value,
   input  logic                          csr_valid,
   input  logic [lkvc_pkg::CAP_W-1:0]    csr_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_found,
   output logic [lkvc_pkg::VALUE_W-1:0]  rsp_data
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // memories
   logic [lkvc_pkg::KEY_W-1:0]   key_mem [ENTRIES];
   logic [lkvc_pkg::VALUE_W-1:0] val_mem [ENTRIES];

   // request held
   logic                         kind_ff;
   logic [lkvc_pkg::KEY_W-1:0]   key_ff;
   logic [lkvc_pkg::VALUE_W-1:0] value_ff;

   // scan pipeline
   logic [IDX_W-1:0]             scan_addr_ff;
   logic                         cmp_vld_ff;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic [lkvc_pkg::KEY_W-1:0]   rd_key_ff;
   logic [lkvc_pkg::VALUE_W-1:0] rd_val_ff;

   // scan results
   logic                         hit_ff;
   logic [IDX_W-1:0]             hit_idx_ff;
   logic [RANK_W-1:0]            hit_rank_ff;
   logic [lkvc_pkg::VALUE_W-1:0] hit_val_ff;
   logic                         old_ff;
   logic [IDX_W-1:0]             old_idx_ff;
   logic [RANK_W-1:0]            old_rank_ff;
   logic                         free_ff;
   logic [IDX_W-1:0]             free_idx_ff;

   // cache state
   logic [ENTRIES-1:0]           valid_ff;
   logic [ENTRIES-1:0]           valid_in;
   logic [RANK_W-1:0]            rank_ff [ENTRIES];
   logic [RANK_W-1:0]            rank_in [ENTRIES];
   logic [OCC_W-1:0]             occ_ff;
   logic [OCC_W-1:0]             occ_in;
   logic [lkvc_pkg::CAP_W-1:0]   cap_ff;

   // result register
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic [lkvc_pkg::VALUE_W-1:0] rsp_data_ff;

   logic                         cmp_valid_bit;
   logic [RANK_W-1:0]            cmp_rank;
   logic                         cmp_match;
   logic [CMP_W-1:0]             cap_ext;
   logic [CMP_W-1:0]             eff_cap;
   logic                         evict;
   logic                         is_store;
   logic [IDX_W-1:0]             slot;

   assign cmp_valid_bit = valid_ff[cmp_idx_ff];
   assign cmp_rank      = rank_ff[cmp_idx_ff];
   assign cmp_match     = cmp_vld_ff && cmp_valid_bit && (rd_key_ff == key_ff);

   // zero capacity behaves as one, above the entry count saturates
   assign cap_ext = CMP_W'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict    = (CMP_W'(occ_ff) >= eff_cap);
   assign is_store = (kind_ff == lkvc_pkg::KIND_STORE);
   assign slot     = evict ? old_idx_ff : free_idx_ff;

   // request capture and scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (cmd.scan_en) begin
         rd_key_ff <= key_mem[scan_addr_ff];
         rd_val_ff <= val_mem[scan_addr_ff];
      end
      cmp_idx_ff <= scan_addr_ff;
      if (cmp_match && !hit_ff) begin
         hit_idx_ff  <= cmp_idx_ff;
         hit_rank_ff <= cmp_rank;
         hit_val_ff  <= rd_val_ff;
      end
      if (cmp_vld_ff && cmp_valid_bit && (!old_ff || cmp_rank >= old_rank_ff)) begin
         old_idx_ff  <= cmp_idx_ff;
         old_rank_ff <= cmp_rank;
      end
      if (cmp_vld_ff && !cmp_valid_bit && !free_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         old_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_en;
         if (cmd.load) begin
            scan_addr_ff <= '0;
            hit_ff       <= 1'b0;
            old_ff       <= 1'b0;
            free_ff      <= 1'b0;
         end else begin
            if (cmd.scan_en && scan_addr_ff != LAST_IDX) begin
               scan_addr_ff <= scan_addr_ff + IDX_W'(1);
            end
            if (cmp_match) hit_ff <= 1'b1;
            if (cmp_vld_ff && cmp_valid_bit) old_ff <= 1'b1;
            if (cmp_vld_ff && !cmp_valid_bit) free_ff <= 1'b1;
         end
      end
   end

   // memory writes on a store
   always_ff @(posedge clock) begin
      if (cmd.act && is_store) begin
         if (hit_ff) begin
            val_mem[hit_idx_ff] <= value_ff;
         end else begin
            val_mem[slot] <= value_ff;
            key_mem[slot] <= key_ff;
         end
      end
   end

   // recency update: touch on a hit, age all others on an insert
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.act && hit_ff) begin
            if (IDX_W'(i) == hit_idx_ff) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank_ff) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end else if (cmd.act && is_store) begin
            if (IDX_W'(i) == slot) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      if (cmd.act && is_store && !hit_ff && !evict) begin
         occ_in = occ_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.act && !is_store) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act && !is_store) begin
         rsp_found_ff <= hit_ff;
         rsp_data_ff  <= hit_ff ? hit_val_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_data   = rsp_data_ff;

   assign status.scan_last = (scan_addr_ff == LAST_IDX);
   assign status.act_ok    = is_store || !rsp_valid_ff || rsp_tready;
   assign status.lookup    = !is_store;

endmodule

// ----- dv/tb.sv -----
// testbench for lru_key_value_cache_unit: directed table, then random phases at several capacities
// depends on lkvc_pkg and the lru_key_value_cache_unit rtl; lookups are scored against an lru model or typed answers
`timescale 1ns / 100ps

module tb;

   localparam int  SLOTS       = lkvc_pkg::DEFAULT_ENTRIES;
   localparam int  CAP_W       = lkvc_pkg::CAP_W;
   localparam real CLK_PERIOD  = 12.0;
   localparam int  SETTLE      = 2 * (SLOTS + 3);
   localparam int  PHASES      = 9;
   localparam int  PHASE_ITEMS = 200;
   localparam int  POOL        = 24;

   typedef struct packed {
      logic        found;
      logic [31:0] data;
   } answer_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] key;
      logic [31:0] value;
      logic        pinned;  // answer typed in below instead of taken from the model
      logic        found;
      logic [31:0] data;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [63:0]      req_tdata;   // [31:0] key, [63:32] value
   logic             req_tuser;   // [0] kind
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;   // [31:0] data
   logic             rsp_tuser;   // [0] found
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data;

   lru_key_value_cache_unit #(.ENTRIES(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // cache model state
   logic [31:0]      slot_key   [SLOTS];
   logic [31:0]      slot_value [SLOTS];
   bit               slot_valid [SLOTS];
   int unsigned      slot_rank  [SLOTS];
   int unsigned      fill;
   logic [CAP_W-1:0] cap_reg;

   answer_type  pending_answers[$];
   logic [31:0] key_pool[POOL];
   bit          idle_on;
   int          stall_left = 0;
   int          errors = 0;
   int          n_lookups, n_hits, n_stores, n_settings;

   stim_row_type dir_rows[19] = '{
      '{lkvc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_STORE,  32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7fff_ffff},
      '{lkvc_pkg::KIND_STORE,  32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{lkvc_pkg::KIND_STORE,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      // overwrite of a present key
      '{lkvc_pkg::KIND_STORE,  32'h8000_0000, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
      '{lkvc_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_STORE,  32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff},
      // value field is don't-care on a lookup
      '{lkvc_pkg::KIND_LOOKUP, 32'h0000_0000, 32'hdead_beef, 1'b1, 1'b1, 32'h0000_0000},
      '{lkvc_pkg::KIND_STORE,  32'h0000_0001, 32'ha5a5_a5a5, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_STORE,  32'h5555_5555, 32'haaaa_aaaa, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{lkvc_pkg::KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
   };

   logic [CAP_W-1:0] cap_plan[PHASES] = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd9, 5'd16, 5'd17, 5'd5};

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   function automatic int eff_capacity(input logic [CAP_W-1:0] cap);
      if (cap == 0)
         return 1;
      if (cap > SLOTS)
         return SLOTS;
      return int'(cap);
   endfunction

   function automatic int find_slot(input logic [31:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   // move one entry to the front; younger entries age by one
   function automatic void promote(input int idx);
      int unsigned r;
      r = slot_rank[idx];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_rank[i] < r)
            slot_rank[i]++;
      slot_rank[idx] = 0;
   endfunction

   // returns 1 when the request produces an answer
   function automatic bit cache_access(input logic kind, input logic [31:0] key,
                                       input logic [31:0] value, output answer_type ans);
      int hit, slot;
      int unsigned oldest_rank;
      hit = find_slot(key);
      ans = '0;
      if (kind == lkvc_pkg::KIND_LOOKUP) begin
         if (hit >= 0) begin
            promote(hit);
            ans.found = 1'b1;
            ans.data  = slot_value[hit];
         end
         return 1'b1;
      end
      if (hit >= 0) begin
         slot_value[hit] = value;
         promote(hit);
         return 1'b0;
      end
      slot = -1;
      if (fill >= eff_capacity(cap_reg) || fill >= SLOTS) begin
         // last entry holding the largest rank goes
         oldest_rank = 0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && (slot < 0 || slot_rank[i] >= oldest_rank)) begin
               slot = i;
               oldest_rank = slot_rank[i];
            end
         if (slot >= 0) begin
            slot_valid[slot] = 1'b0;
            fill--;
         end
      end
      if (slot < 0)
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_valid[i])
               slot = i;
      if (slot < 0)
         return 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i])
            slot_rank[i]++;
      slot_key[slot]   = key;
      slot_value[slot] = value;
      slot_valid[slot] = 1'b1;
      slot_rank[slot]  = 0;
      fill++;
      return 1'b0;
   endfunction

   task automatic send_request(input logic kind, input logic [31:0] key, input logic [31:0] value,
                               input logic pinned, input answer_type typed);
      int gap;
      answer_type ans;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      if (cache_access(kind, key, value, ans)) begin
         n_lookups++;
         if (ans.found)
            n_hits++;
         pending_answers.push_back(pinned ? typed : ans);
      end else begin
         n_stores++;
      end
   endtask

   // stores give no answer, so allow the last one to finish before a register write
   task automatic drain;
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = cap;
      n_settings++;
   endtask

   function automatic logic [31:0] pick_key(input int pool_hi);
      if ($urandom_range(0, 9) == 0)
         return $urandom;
      return key_pool[$urandom_range(0, pool_hi)];
   endfunction

   // response side: check every transaction, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response, found %0b data %h", $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            answer_type want;
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.found) begin
               $display("%0t: found mismatch, expected %0b got %0b", $time, want.found, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== want.data) begin
               $display("%0t: data mismatch, expected %h got %h", $time, want.data, rsp_tdata);
               errors++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [CAP_W-1:0] cap;
      int pool_hi;
      logic kind;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = lkvc_pkg::KIND_LOOKUP;
      csr_valid  = 1'b0;
      csr_data   = '0;
      n_lookups  = 0;
      n_hits     = 0;
      n_stores   = 0;
      n_settings = 0;
      idle_on    = 1'b1;
      cap_reg    = lkvc_pkg::CAP_RESET;
      fill       = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_rank[i]  = 0;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL; i++)
         key_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r])
         send_request(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].value,
                      dir_rows[r].pinned, {dir_rows[r].found, dir_rows[r].data});

      // first phase fills at capacity 16, the second drops to 2 with the cache full
      for (int p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         drain();
         cap = (p == PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : cap_plan[p];
         write_capacity(cap);
         for (int i = 12; i < POOL; i++)
            key_pool[i] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0)
               idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pool_hi = eff_capacity(cap) + $urandom_range(0, 6);
            if (pool_hi > POOL - 1)
               pool_hi = POOL - 1;
            kind = ($urandom_range(0, 99) < 55) ? lkvc_pkg::KIND_LOOKUP : lkvc_pkg::KIND_STORE;
            send_request(kind, pick_key(pool_hi), $urandom, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
      drain();

      $display("run covered %0d requests: %0d lookups with %0d hits, %0d stores",
               n_lookups + n_stores, n_lookups, n_hits, n_stores);
      $display("capacity written %0d times, including zero, one, full and saturating values",
               n_settings);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("timeout with %0d answers outstanding", pending_answers.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lkvc_pkg.sv
design/lkvc_ctrl.sv
design/lkvc_datapath.sv
design/lru_key_value_cache_unit.sv
dv/tb.sv
